// File: rtl/core/tli_pkg.sv
// Shared constants for the table linear interpolator.
// Field widths, register reset value, command and range-flag codes.
// No dependencies.
package tli_pkg;

    // Integer bits of every Q-format value
    localparam int INT_BITS = 16;

    // Defaults for the top-level parameters
    localparam int TABLE_DEPTH_DEF = 512;
    localparam int FRAC_BITS_DEF   = 32;

    // Fixed field widths
    localparam int ROW_INDEX_W = 9;
    localparam int LAST_ROW_W  = 9;
    localparam int FLAG_W      = 2;

    // Register reset value
    localparam logic [LAST_ROW_W-1:0] LAST_ROW_RESET = 9'd275;

    // Command codes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Range flag codes
    localparam logic [FLAG_W-1:0] FLAG_INTERP = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_TOP    = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_BOTTOM = 2'd2;

endpackage

// File: rtl/core/tli_muldiv.sv
// Bit-serial exact multiply-divide: q = floor(a * b / d), with b < d.
// One bit of a per cycle, MSB first; no package dependency.
// Used twice by table_linear_interpolator, one per table column.
module tli_muldiv #(
    parameter int W = 48
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] d,
    output logic [W-1:0] q,
    output logic         done
);

    localparam int S     = W + 3;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    logic [W-1:0]     a_reg;
    logic [W-1:0]     r_reg;
    logic [W-1:0]     q_reg;
    logic [S-1:0]     b_reg;
    logic [S-1:0]     k1b_reg;
    logic [S-1:0]     k2b_reg;
    logic [S-1:0]     k1n_reg;
    logic [S-1:0]     k2n_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [S-1:0] b_ext;
    logic [S-1:0] d_ext;
    logic [S-1:0] d2_ext;
    logic [S-1:0] two_r;
    logic [S-1:0] x0;
    logic [S-1:0] x1;
    logic [S-1:0] x2;
    logic         a_bit;
    logic [W-1:0] r_next;
    logic [1:0]   inc;
    logic [W-1:0] q_next;

    assign b_ext  = {3'b000, b};
    assign d_ext  = {3'b000, d};
    assign d2_ext = {2'b00, d, 1'b0};

    // One step: remainder doubles, then b joins it when the bit of a is set.
    // Candidates with zero, one and two times d taken off are formed side by side.
    assign a_bit = a_reg[W-1];
    assign two_r = {2'b00, r_reg, 1'b0};
    assign x0    = two_r + (a_bit ? b_reg : '0);
    assign x1    = two_r + (a_bit ? k1b_reg : k1n_reg);
    assign x2    = two_r + (a_bit ? k2b_reg : k2n_reg);

    always_comb
    begin
        if (!x2[S-1])
        begin
            r_next = x2[W-1:0];
            inc    = 2'd2;
        end
        else if (!x1[S-1])
        begin
            r_next = x1[W-1:0];
            inc    = 2'd1;
        end
        else
        begin
            r_next = x0[W-1:0];
            inc    = 2'd0;
        end
    end

    assign q_next = {q_reg[W-2:0], 1'b0} + W'(inc);

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands and offsets, then advance one bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            r_reg   <= '0;
            q_reg   <= '0;
            b_reg   <= b_ext;
            k1b_reg <= b_ext - d_ext;
            k2b_reg <= b_ext - d2_ext;
            k1n_reg <= S'(0) - d_ext;
            k2n_reg <= S'(0) - d2_ext;
        end
        else if (run_reg)
        begin
            a_reg <= {a_reg[W-2:0], 1'b0};
            r_reg <= r_next;
            q_reg <= q_next;
        end
    end

    assign q    = q_reg;
    assign done = done_reg;

endmodule

// File: rtl/core/table_linear_interpolator.sv
// Table linear interpolator: loads rows, answers queries by a walk and a divide.
// Load: written when accepted, no result. A query ends clamped at the top row, at the last
// row when the temperature or last_row is zero or the walk from row 1 runs below the table,
// or interpolated between two rows by the column dividers.
// One item at a time: busy drops in the result cycle; the receiver cannot stall.
// Reset clears control and sets last_row to 275; table contents are undefined until loaded.
module table_linear_interpolator
    import tli_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic [ROW_INDEX_W-1:0]        row_index,
    input  logic [INT_BITS+FRAC_BITS-1:0] temperature,
    input  logic [INT_BITS+FRAC_BITS-1:0] row_entropy_ratio,
    input  logic [INT_BITS+FRAC_BITS-1:0] row_dof,
    input  logic                          cfg_write,
    input  logic [LAST_ROW_W-1:0]         cfg_data,
    output logic                          done,
    output logic [INT_BITS+FRAC_BITS-1:0] entropy_ratio_value,
    output logic [INT_BITS+FRAC_BITS-1:0] dof_value,
    output logic [FLAG_W-1:0]             range_flag
);

    localparam int W      = INT_BITS + FRAC_BITS;
    localparam int ROW_W  = 3 * W;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CMP_W  = ((ADDR_W > ROW_INDEX_W) ? ADDR_W : ROW_INDEX_W) + 1;
    localparam logic [ADDR_W-1:0] ADDR_MAX   = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [ADDR_W-1:0] ADDR_ONE   = ADDR_W'(1);
    localparam logic [CMP_W-1:0]  DEPTH_CMP  = CMP_W'(TABLE_DEPTH);
    localparam logic [CMP_W-1:0]  MAX_CMP    = CMP_W'(TABLE_DEPTH - 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ROW0   = 7'b0000010,
        ST_SEARCH = 7'b0000100,
        ST_LAST   = 7'b0001000,
        ST_SETUP  = 7'b0010000,
        ST_START  = 7'b0100000,
        ST_DIVIDE = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [LAST_ROW_W-1:0] last_row_reg;

    // Row memory: {temperature, entropy ratio, dof}
    logic [ROW_W-1:0]  row_mem [TABLE_DEPTH];
    logic [ROW_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [CMP_W-1:0]  idx_ext;
    logic              wr_en;

    logic [W-1:0] rd_t;
    logic [W-1:0] rd_e;
    logic [W-1:0] rd_d;

    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] last_clamp;
    logic [CMP_W-1:0]  last_ext;

    logic [W-1:0] t_reg;
    logic [W-1:0] prev_t_reg;
    logic [W-1:0] prev_e_reg;
    logic [W-1:0] prev_d_reg;
    logic [W-1:0] cur_t_reg;
    logic [W-1:0] cur_e_reg;
    logic [W-1:0] cur_d_reg;

    logic [W-1:0] den_reg;
    logic [W-1:0] dt_reg;
    logic [W-1:0] e_abs_reg;
    logic [W-1:0] d_abs_reg;
    logic         e_neg_reg;
    logic         d_neg_reg;

    logic [W:0]   e_diff;
    logic [W:0]   d_diff;

    logic [W-1:0]      ent_out_reg;
    logic [W-1:0]      dof_out_reg;
    logic [FLAG_W-1:0] flag_reg;
    logic              done_reg;

    logic load_accept;
    logic query_accept;
    logic t_ge;
    logic go_last;
    logic at_last;
    logic emit_row;
    logic [FLAG_W-1:0] emit_flag;

    logic         md_start;
    logic [W-1:0] q_e;
    logic [W-1:0] q_d;
    logic         md_done_e;
    logic         md_done_d;

    assign busy         = (state_reg != ST_IDLE);
    assign load_accept  = start && !busy && (mode == MODE_LOAD);
    assign query_accept = start && !busy && (mode == MODE_QUERY);

    // Clamp the final row to the table
    assign last_ext   = CMP_W'(last_row_reg);
    assign last_clamp = (last_ext > MAX_CMP) ? ADDR_MAX : last_ext[ADDR_W-1:0];

    assign rd_t = rd_data_reg[ROW_W-1:2*W];
    assign rd_e = rd_data_reg[2*W-1:W];
    assign rd_d = rd_data_reg[W-1:0];

    assign t_ge    = (t_reg >= rd_t);
    assign go_last = (t_reg == '0) || (last_clamp == '0);
    assign at_last = (idx_reg == last_clamp);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_row_reg <= LAST_ROW_RESET;
        end
        else if (cfg_write)
        begin
            last_row_reg <= cfg_data;
        end
    end

    // Write port: drop loads beyond the table
    assign idx_ext = CMP_W'(row_index);
    assign wr_addr = idx_ext[ADDR_W-1:0];
    assign wr_en   = load_accept && (idx_ext < DEPTH_CMP);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= {temperature, row_entropy_ratio, row_dof};
        end
    end

    // Read address follows the walk one row ahead
    always_comb
    begin
        unique case (state_reg)
            ST_ROW0:   rd_addr = go_last ? last_clamp : ADDR_ONE;
            ST_SEARCH: rd_addr = idx_reg + 1'b1;
            default:   rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= row_mem[rd_addr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_accept)
                begin
                    state_next = ST_ROW0;
                end
            end
            ST_ROW0:
            begin
                if (t_ge)
                begin
                    state_next = ST_IDLE;
                end
                else if (go_last)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (t_ge)
                begin
                    state_next = ST_SETUP;
                end
                else if (at_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LAST:   state_next = ST_IDLE;
            ST_SETUP:  state_next = ST_START;
            ST_START:  state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (md_done_e)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Walk index and bracketing rows
    always_ff @(posedge clk)
    begin
        if (query_accept)
        begin
            t_reg <= temperature;
        end
        if (state_reg == ST_ROW0)
        begin
            idx_reg    <= ADDR_ONE;
            prev_t_reg <= rd_t;
            prev_e_reg <= rd_e;
            prev_d_reg <= rd_d;
        end
        else if (state_reg == ST_SEARCH)
        begin
            if (t_ge)
            begin
                cur_t_reg <= rd_t;
                cur_e_reg <= rd_e;
                cur_d_reg <= rd_d;
            end
            else
            begin
                idx_reg    <= idx_reg + 1'b1;
                prev_t_reg <= rd_t;
                prev_e_reg <= rd_e;
                prev_d_reg <= rd_d;
            end
        end
    end

    // Interval width, offset and column spans with their direction
    assign e_diff = {1'b0, prev_e_reg} - {1'b0, cur_e_reg};
    assign d_diff = {1'b0, prev_d_reg} - {1'b0, cur_d_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SETUP)
        begin
            den_reg   <= prev_t_reg - cur_t_reg;
            dt_reg    <= t_reg - cur_t_reg;
            e_neg_reg <= e_diff[W];
            d_neg_reg <= d_diff[W];
            e_abs_reg <= e_diff[W] ? (cur_e_reg - prev_e_reg) : e_diff[W-1:0];
            d_abs_reg <= d_diff[W] ? (cur_d_reg - prev_d_reg) : d_diff[W-1:0];
        end
    end

    assign md_start = (state_reg == ST_START);

    tli_muldiv #(
        .W (W)
    ) u_muldiv_e (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .a     (e_abs_reg),
        .b     (dt_reg),
        .d     (den_reg),
        .q     (q_e),
        .done  (md_done_e)
    );

    tli_muldiv #(
        .W (W)
    ) u_muldiv_d (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .a     (d_abs_reg),
        .b     (dt_reg),
        .d     (den_reg),
        .q     (q_d),
        .done  (md_done_d)
    );

    // Result word: a stored row on clamps, the interpolated pair otherwise
    assign emit_row = ((state_reg == ST_ROW0) && t_ge)
                   || ((state_reg == ST_SEARCH) && !t_ge && at_last)
                   || (state_reg == ST_LAST);
    assign emit_flag = ((state_reg == ST_ROW0) && t_ge) ? FLAG_TOP : FLAG_BOTTOM;

    always_ff @(posedge clk)
    begin
        if (emit_row)
        begin
            ent_out_reg <= rd_e;
            dof_out_reg <= rd_d;
            flag_reg    <= emit_flag;
        end
        else if ((state_reg == ST_DIVIDE) && md_done_e)
        begin
            ent_out_reg <= e_neg_reg ? (cur_e_reg - q_e) : (cur_e_reg + q_e);
            dof_out_reg <= d_neg_reg ? (cur_d_reg - q_d) : (cur_d_reg + q_d);
            flag_reg    <= FLAG_INTERP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= emit_row || ((state_reg == ST_DIVIDE) && md_done_e);
        end
    end

    assign done                = done_reg;
    assign entropy_ratio_value = ent_out_reg;
    assign dof_value           = dof_out_reg;
    assign range_flag          = flag_reg;

    // A result word only follows a cycle of work on a query
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result word without a query in progress");

    // Both column dividers run in lockstep
    assert property (@(posedge clk) disable iff (!rst_n) md_done_e == md_done_d)
        else $error("column dividers out of step");

    // Quotient never exceeds the column span, so the result stays in the interval
    assert property (@(posedge clk) disable iff (!rst_n)
        md_done_e |-> ((q_e <= e_abs_reg) && (q_d <= d_abs_reg)))
        else $error("divider quotient beyond column span");

    // An accepted query keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) query_accept |=> busy)
        else $error("query accepted without entering the walk");

endmodule

// File: sim/table_linear_interpolator_tb.sv
// Self-checking testbench for the table linear interpolator.
// Loads row tables, sends query words and checks each result against its own predictor or a directed value.
// Depends on tli_pkg and table_linear_interpolator.
module table_linear_interpolator_tb;

    import tli_pkg::*;

    localparam int VW             = INT_BITS + FRAC_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DIR_ROWS       = 25;

    typedef logic [VW-1:0]     value_t;
    typedef logic [FLAG_W-1:0] flag_t;

    typedef struct packed {
        value_t er;
        value_t dof;
        flag_t  flag;
    } result_t;

    typedef enum logic [1:0] {
        STEP_LOAD,
        STEP_QUERY,
        STEP_CFG
    } step_t;

    // One directed step; arg is the row index of a load or the last_row value of a write
    typedef struct packed {
        step_t                  kind;
        logic [ROW_INDEX_W-1:0] arg;
        value_t                 t;
        value_t                 er;
        value_t                 dof;
        logic                   typed;
        value_t                 x_er;
        value_t                 x_dof;
        flag_t                  x_flag;
    } stim_row_t;

    localparam bit [63:0] VALUE_SPAN = (64'd1 << VW) - 64'd1;

    localparam value_t V_MAX  = {VW{1'b1}};
    localparam value_t T_200  = 48'h00C8_0000_0000;
    localparam value_t T_100  = 48'h0064_0000_0000;
    localparam value_t T_90   = 48'h005A_0000_0000;
    localparam value_t T_85   = 48'h0055_0000_0000;
    localparam value_t T_80   = 48'h0050_0000_0000;
    localparam value_t T_79   = 48'h004F_0000_0000;
    localparam value_t T_50   = 48'h0032_0000_0000;
    localparam value_t T_35   = 48'h0023_0000_0000;
    localparam value_t T_20   = 48'h0014_0000_0000;
    localparam value_t T_1    = 48'h0001_0000_0000;
    localparam value_t R2_ER  = 48'h0003_8000_0000;
    localparam value_t R2_DOF = 48'h0002_0000_0000;
    localparam value_t R3_ER  = 48'h0001_0000_0000;
    localparam value_t R3_DOF = 48'h0007_0000_0000;
    localparam value_t RB_ER  = 48'h0000_1234_5678;
    localparam value_t RB_DOF = 48'hABCD_0000_0001;

    logic                   clk               = 1'b0;
    logic                   rst_n             = 1'b0;
    logic                   start             = 1'b0;
    logic                   busy;
    logic                   mode              = MODE_LOAD;
    logic [ROW_INDEX_W-1:0] row_index         = '0;
    value_t                 temperature       = '0;
    value_t                 row_entropy_ratio = '0;
    value_t                 row_dof           = '0;
    logic                   cfg_write         = 1'b0;
    logic [LAST_ROW_W-1:0]  cfg_data          = '0;
    logic                   done;
    value_t                 entropy_ratio_value;
    value_t                 dof_value;
    flag_t                  range_flag;

    // Shadow of the row store and the register
    value_t                tbl_temp [TABLE_DEPTH_DEF];
    value_t                tbl_er   [TABLE_DEPTH_DEF];
    value_t                tbl_dof  [TABLE_DEPTH_DEF];
    logic [LAST_ROW_W-1:0] last_row_q = LAST_ROW_RESET;

    result_t pending_results [$];
    int      mismatches  = 0;
    int      idle_cycles = 0;
    int      burst_left  = 0;

    // Extremes, every clamp, exact row hits, last_row of zero and unordered tables
    stim_row_t directed_rows [DIR_ROWS] = '{
        '{STEP_LOAD,  9'd0,   T_100, V_MAX, 48'd0,  1'b0, 48'd0,  48'd0,  FLAG_INTERP},
        '{STEP_LOAD,  9'd275, T_1,   RB_ER, RB_DOF, 1'b0, 48'd0,  48'd0,  FLAG_INTERP},
        '{STEP_QUERY, 9'd0,   48'd0, 48'd0, 48'd0,  1'b1, RB_ER,  RB_DOF, FLAG_BOTTOM},
        '{STEP_QUERY, 9'd0,   V_MAX, 48'd0, 48'd0,  1'b1, V_MAX,  48'd0,  FLAG_TOP},
        '{STEP_QUERY, 9'd0,   T_100, 48'd0, 48'd0,  1'b1, V_MAX,  48'd0,  FLAG_TOP},
        '{STEP_CFG,   9'd3,   48'd0, 48'd0, 48'd0,  1'b0, 48'd0,  48'd0,  FLAG_INTERP},
        '{STEP_LOAD,  9'd1,   T_80,  48'd0, V_MAX,  1'b0, 48'd0,  48'd0,  FLAG_INTERP},
        '{STEP_LOAD,  9'd2,   T_50,  R2_ER, R2_DOF, 1'b0, 48'd0,  48'd0,  FLAG_INTERP},
        '{STEP_LOAD,  9'd3,   T_20,  R3_ER, R3_DOF, 1'b0, 48'd0,  48'd0,  FLAG_INTERP},
        '{STEP_QUERY, 9'd0,   T_90,  48'd0, 48'd0,  1'b0, 48'd0,  48'd0,  FLAG_INTERP},
        '{STEP_QUERY, 9'd0,   T_80,  48'd0, 48'd0,  1'b1, 48'd0,  V_MAX,  FLAG_INTERP},
        '{STEP_QUERY, 9'd0,   48'h0063_FFFF_FFFF, 48'd0, 48'd0,
          1'b0, 48'd0, 48'd0, FLAG_INTERP},
        '{STEP_QUERY, 9'd0,   T_35,  48'd0, 48'd0,  1'b0, 48'd0,  48'd0,  FLAG_INTERP},
        '{STEP_QUERY, 9'd0,   T_20,  48'd0, 48'd0,  1'b1, R3_ER,  R3_DOF, FLAG_INTERP},
        '{STEP_QUERY, 9'd0,   48'd1, 48'd0, 48'd0,  1'b1, R3_ER,  R3_DOF, FLAG_BOTTOM},
        '{STEP_QUERY, 9'd0,   48'd0, 48'd0, 48'd0,  1'b1, R3_ER,  R3_DOF, FLAG_BOTTOM},
        '{STEP_CFG,   9'd0,   48'd0, 48'd0, 48'd0,  1'b0, 48'd0,  48'd0,  FLAG_INTERP},
        '{STEP_QUERY, 9'd0,   T_50,  48'd0, 48'd0,  1'b1, V_MAX,  48'd0,  FLAG_BOTTOM},
        '{STEP_QUERY, 9'd0,   48'd0, 48'd0, 48'd0,  1'b1, V_MAX,  48'd0,  FLAG_BOTTOM},
        '{STEP_QUERY, 9'd0,   T_200, 48'd0, 48'd0,  1'b1, V_MAX,  48'd0,  FLAG_TOP},
        '{STEP_CFG,   9'd3,   48'd0, 48'd0, 48'd0,  1'b0, 48'd0,  48'd0,  FLAG_INTERP},
        '{STEP_LOAD,  9'd2,   T_80,  R2_ER, R2_DOF, 1'b0, 48'd0,  48'd0,  FLAG_INTERP},
        '{STEP_QUERY, 9'd0,   T_79,  48'd0, 48'd0,  1'b0, 48'd0,  48'd0,  FLAG_INTERP},
        '{STEP_LOAD,  9'd2,   T_90,  R2_ER, R2_DOF, 1'b0, 48'd0,  48'd0,  FLAG_INTERP},
        '{STEP_QUERY, 9'd0,   T_85,  48'd0, 48'd0,  1'b0, 48'd0,  48'd0,  FLAG_INTERP}
    };

    table_linear_interpolator dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .mode               (mode),
        .row_index          (row_index),
        .temperature        (temperature),
        .row_entropy_ratio  (row_entropy_ratio),
        .row_dof            (row_dof),
        .cfg_write          (cfg_write),
        .cfg_data           (cfg_data),
        .done               (done),
        .entropy_ratio_value(entropy_ratio_value),
        .dof_value          (dof_value),
        .range_flag         (range_flag)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Blend two row values at t, quotient truncated so it stays between them
    function automatic value_t blend(input value_t vlo, input value_t vhi,
                                     input value_t tlo, input value_t thi, input value_t t);
        logic [95:0] span;
        logic [95:0] dt;
        logic [95:0] q;
        span = {48'd0, thi} - {48'd0, tlo};
        dt   = {48'd0, t} - {48'd0, tlo};
        if (vhi >= vlo)
        begin
            q = ({48'd0, vhi} - {48'd0, vlo}) * dt / span;
            return vlo + q[VW-1:0];
        end
        q = ({48'd0, vlo} - {48'd0, vhi}) * dt / span;
        return vlo - q[VW-1:0];
    endfunction

    function automatic result_t predict_query(input value_t t);
        int i;
        if (t >= tbl_temp[0])
            return '{tbl_er[0], tbl_dof[0], FLAG_TOP};
        if (t == '0)
            return '{tbl_er[last_row_q], tbl_dof[last_row_q], FLAG_BOTTOM};
        // Walk down from row 1 to the first row not above t
        for (i = 1; i <= int'(last_row_q); i++)
        begin
            if (t >= tbl_temp[i])
                return '{blend(tbl_er[i], tbl_er[i-1], tbl_temp[i], tbl_temp[i-1], t),
                         blend(tbl_dof[i], tbl_dof[i-1], tbl_temp[i], tbl_temp[i-1], t),
                         FLAG_INTERP};
        end
        return '{tbl_er[last_row_q], tbl_dof[last_row_q], FLAG_BOTTOM};
    endfunction

    function automatic value_t rand_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return V_MAX;
            default: return value_t'({$urandom, $urandom});
        endcase
    endfunction

    // Pick a query point: zero, top, noise, exact rows, near rows, or inside an interval
    function automatic value_t query_point(input int lr);
        int        sel;
        int        k;
        value_t    tlo;
        value_t    thi;
        bit [63:0] pick;
        sel  = $urandom_range(0, 99);
        k    = $urandom_range(0, lr);
        pick = {$urandom, $urandom};
        if (sel < 5)
            return '0;
        if (sel < 10)
            return V_MAX;
        if (sel < 25)
            return value_t'(pick);
        if (sel < 35)
            return tbl_temp[k];
        if (sel < 42)
            return pick[0] ? tbl_temp[k] + 1'b1 : tbl_temp[k] - 1'b1;
        if (k == 0)
            k = 1;
        tlo = tbl_temp[k];
        thi = tbl_temp[k-1];
        if (thi > tlo)
            return tlo + value_t'(pick % (thi - tlo));
        return tlo;
    endfunction

    // Idle the sender between bursts of random length
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
    endtask

    // Offer one word and hold it until accepted, then record what it does
    task automatic send_word(input logic cmd, input logic [ROW_INDEX_W-1:0] idx,
                             input value_t t, input value_t er, input value_t dof,
                             input logic typed, input result_t want);
        start             <= 1'b1;
        mode              <= cmd;
        row_index         <= idx;
        temperature       <= t;
        row_entropy_ratio <= er;
        row_dof           <= dof;
        do
            @(posedge clk);
        while (busy);
        if (cmd == MODE_LOAD)
        begin
            tbl_temp[idx] = t;
            tbl_er[idx]   = er;
            tbl_dof[idx]  = dof;
        end
        else
            pending_results.push_back(typed ? want : predict_query(t));
    endtask

    // Drain every pending result and let a trailing load finish before a register write
    task automatic settle();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_last_row(input logic [LAST_ROW_W-1:0] value);
        settle();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write  <= 1'b0;
        last_row_q  = value;
    endtask

    // Set last_row, load a fresh descending table, then mixed query and load words
    task automatic run_phase(input logic [LAST_ROW_W-1:0] lr, input int n_queries);
        bit [63:0]              stride;
        bit [63:0]              jitter;
        int                     n;
        int                     k;
        logic [ROW_INDEX_W-1:0] idx;
        value_t                 t;
        set_last_row(lr);
        n = int'(lr);
        if ($urandom_range(0, 3) == 0)
            stride = 64'($urandom_range(1, 8));
        else
            stride = 64'd1 + ({$urandom, $urandom} % (VALUE_SPAN / (n + 1)));
        for (k = 0; k <= n; k++)
        begin
            jitter = {$urandom, $urandom} % stride;
            pace();
            send_word(MODE_LOAD, ROW_INDEX_W'(k), value_t'((n - k) * stride + jitter),
                      rand_value(), rand_value(), 1'b0, '0);
        end
        k = 0;
        while (k < n_queries)
        begin
            pace();
            if ($urandom_range(0, 9) == 0)
            begin
                // Rewrite a row, sometimes out of order
                idx = $urandom_range(0, 1) ? ROW_INDEX_W'($urandom_range(0, n))
                                           : ROW_INDEX_W'($urandom);
                t   = ($urandom_range(0, 1) && (int'(idx) <= n)) ? tbl_temp[idx]
                                                                  : rand_value();
                send_word(MODE_LOAD, idx, t, rand_value(), rand_value(), 1'b0, '0);
            end
            else
            begin
                send_word(MODE_QUERY, ROW_INDEX_W'($urandom), query_point(n),
                          rand_value(), rand_value(), 1'b0, '0);
                k++;
            end
        end
    endtask

    // Check each result word against the oldest pending expectation
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no query pending: %h %h %0d",
                       entropy_ratio_value, dof_value, range_flag);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (entropy_ratio_value !== want.er)
                begin
                    $error("entropy_ratio_value: expected %h, got %h",
                           want.er, entropy_ratio_value);
                    mismatches++;
                end
                if (dof_value !== want.dof)
                begin
                    $error("dof_value: expected %h, got %h", want.dof, dof_value);
                    mismatches++;
                end
                if (range_flag !== want.flag)
                begin
                    $error("range_flag: expected %0d, got %0d", want.flag, range_flag);
                    mismatches++;
                end
            end
        end
    end

    // Stop a run in which no word moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                    p;
        int                    r;
        logic [LAST_ROW_W-1:0] lr;
        int                    n_queries;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed steps
        for (r = 0; r < DIR_ROWS; r++)
        begin
            if (directed_rows[r].kind == STEP_CFG)
                set_last_row(directed_rows[r].arg);
            else
            begin
                pace();
                send_word(directed_rows[r].kind == STEP_LOAD ? MODE_LOAD : MODE_QUERY,
                          directed_rows[r].arg, directed_rows[r].t, directed_rows[r].er,
                          directed_rows[r].dof, directed_rows[r].typed,
                          '{directed_rows[r].x_er, directed_rows[r].x_dof,
                            directed_rows[r].x_flag});
            end
        end

        // Random phases; long tables get few queries since each walks many rows
        for (p = 0; p < 8; p++)
        begin
            case (p)
                0:       lr = 9'd1;
                1:       lr = 9'd511;
                2:       lr = 9'd2;
                3:       lr = LAST_ROW_RESET;
                4, 5:    lr = LAST_ROW_W'($urandom_range(3, 15));
                6:       lr = LAST_ROW_W'($urandom_range(16, 64));
                default: lr = 9'd8;
            endcase
            n_queries = (lr > 200) ? 25 : (lr > 15) ? 90 : 120;
            run_phase(lr, n_queries);
        end

        // Drain, then watch a while for stray results
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
